>>> sv/arm_ik_pkg.sv
// Shared types, constants and helper functions for the arm inverse kinematics block.
// No dependencies; every other file imports it.
package arm_ik_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 16;
    localparam int TABLE_LEN       = 24;
    localparam int GUARD_BITS      = 16;
    localparam int SQRT_CELLS      = 16;   // 32 bit radicand, two bits per cell
    localparam int ANG_W           = ANGLE_FRAC_BITS + 10;
    localparam int CW              = 36;   // cordic vector width

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 2**ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 2**ANGLE_FRAC_BITS);

    // register indexes
    localparam logic [2:0] REG_FIRST  = 3'd0;
    localparam logic [2:0] REG_SECOND = 3'd1;
    localparam logic [2:0] REG_SPEED  = 3'd2;
    localparam logic [2:0] REG_LIMIT  = 3'd3;
    localparam logic [2:0] REG_ELBOW  = 3'd4;
    localparam logic [2:0] REG_WRIST  = 3'd5;

    // servo ids
    localparam logic [1:0] ID_BASE  = 2'd0;
    localparam logic [1:0] ID_WRIST = 2'd3;

    typedef struct packed {
        logic [31:0] rad;
        logic [17:0] rem;
        logic [15:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } t_cordic;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_xyz;

    typedef struct packed {
        logic signed [15:0]      y;
        logic signed [15:0]      x;
        logic signed [15:0]      z;
        logic [15:0]             sh;
        logic signed [17:0]      p;
        logic                    spec;
        logic signed [ANG_W-1:0] spec_ang;
    } t_mid;

    typedef struct packed {
        logic                    spec;
        logic signed [ANG_W-1:0] spec_ang;
    } t_spec;

    // atan(2^-i) in degrees, scaled by 2^24
    function automatic logic [31:0] atan_q24(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489088;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] step_angle(input logic [4:0] i);
        logic [31:0] t;
        t = atan_q24(i) + (32'd1 << (23 - ANGLE_FRAC_BITS));
        return ANG_W'(t >> (24 - ANGLE_FRAC_BITS));
    endfunction

    // scale, then turn a vector with negative x into the right half plane
    function automatic t_cordic prerot(input logic signed [17:0] num,
                                       input logic signed [17:0] den);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        t_cordic c;
        xs = $signed({{(CW-18-GUARD_BITS){den[17]}}, den, {GUARD_BITS{1'b0}}});
        ys = $signed({{(CW-18-GUARD_BITS){num[17]}}, num, {GUARD_BITS{1'b0}}});
        c.zero = (num == 18'sd0) && (den == 18'sd0);
        c.x = xs;
        c.y = ys;
        c.ang = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                c.x = ys;
                c.y = -xs;
                c.ang = DEG90;
            end else begin
                c.x = -ys;
                c.y = xs;
                c.ang = -DEG90;
            end
        end
        return c;
    endfunction

    // truncate to whole degrees, subtract offset, clamp to 0..lim
    function automatic logic [7:0] cmd_angle(input logic signed [ANG_W-1:0] a,
                                             input logic [7:0] off,
                                             input logic [7:0] lim);
        logic signed [ANG_W-1:0] m;
        logic signed [ANG_W+1:0] w;
        logic [7:0] res;
        m = (a >= 0) ? (a >>> ANGLE_FRAC_BITS) : -((-a) >>> ANGLE_FRAC_BITS);
        w = $signed({{2{m[ANG_W-1]}}, m}) - $signed({{(ANG_W-6){1'b0}}, off});
        if (w < 0)
            res = 8'd0;
        else if (w > $signed({{(ANG_W-6){1'b0}}, lim}))
            res = lim;
        else
            res = w[7:0];
        return res;
    endfunction

endpackage

>>> sv/arm_inverse_kinematics.sv
// Top level: pipelined inverse kinematics for a four-servo arm.
// Depends on arm_ik_pkg, arm_ik_sqrt_cell, arm_ik_cordic_cell, arm_ik_out.
//
// Usage
//   Input channel: i_in_valid / o_in_stall with a target point x, y, z in
//   signed Q8.8. Output channel: o_out_valid / i_out_stall, four commands
//   per item, servo ids 0 to 3 in order, o_last_command set on id 3.
//   Config port: i_cfg_valid / o_cfg_ready (always ready), index 0..5,
//   other indexes ignored. Write only while the block is idle.
//   Stages from accept to the first command: 3 setup stages, two chains of
//   16 square root cells, 3 acos setup stages, one prerotate stage, the
//   atan2 cell chain, two angle stages and the command register. The other
//   three commands follow one per cycle while the receiver does not stall.
//   Throughput: the cell chains take a new item every cycle while the
//   pipeline is not held; the four-command serializer limits the sustained
//   rate, loading the next item as the last command of the current one is taken.
//   When the receiver stalls, the whole pipeline holds once the last angle
//   stage is full, and o_in_stall rises.
//   Reset clears all valid bits and loads the register defaults; no item is
//   in flight afterwards.
module arm_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_target_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_servo_id,
    output logic [7:0]         o_servo_angle,
    output logic [7:0]         o_servo_rate,
    output logic               o_last_command,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    import arm_ik_pkg::*;

    // configuration
    logic [14:0] r_first;
    logic [14:0] r_second;
    logic [7:0]  r_speed;
    logic [7:0]  r_limit;
    logic [7:0]  r_elbow;
    logic [7:0]  r_wrist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 15'd3840;
            r_second <= 15'd3200;
            r_speed  <= 8'd120;
            r_limit  <= 8'd170;
            r_elbow  <= 8'd25;
            r_wrist  <= 8'd90;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FIRST:  r_first  <= i_cfg_data;
                REG_SECOND: r_second <= i_cfg_data;
                REG_SPEED:  r_speed  <= i_cfg_data[7:0];
                REG_LIMIT:  r_limit  <= i_cfg_data[7:0];
                REG_ELBOW:  r_elbow  <= i_cfg_data[7:0];
                REG_WRIST:  r_wrist  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic take;
    logic r_fin_vld;

    assign en         = !r_fin_vld || take;
    assign o_in_stall = !en;

    // stage 0: input
    logic r_v0;
    t_xyz r_p0;
    // stage 1: squares
    logic        r_v1;
    t_xyz        r_p1;
    logic [31:0] r_xx, r_yy, r_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= '{x: i_target_x, y: i_target_y, z: i_target_z};
            r_p1 <= r_p0;
            r_xx <= 32'(r_p0.x * r_p0.x);
            r_yy <= 32'(r_p0.y * r_p0.y);
            r_zz <= 32'(r_p0.z * r_p0.z);
        end
    end

    // stage 2 is element 0 of chain A: radius and horizontal radius sqrt
    logic        r_va [0:SQRT_CELLS];
    t_xyz        r_ca [0:SQRT_CELLS];
    logic [31:0] r_r2, r_hz;
    t_sqrt       w_sr [0:SQRT_CELLS];
    t_sqrt       w_sh [0:SQRT_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_va[0] <= 1'b0;
        else if (en)
            r_va[0] <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca[0] <= r_p1;
            r_r2    <= r_xx + r_yy + r_zz;
            r_hz    <= r_xx + r_zz;
        end
    end

    assign w_sr[0] = '{rad: r_r2, rem: '0, root: '0};
    assign w_sh[0] = '{rad: r_hz, rem: '0, root: '0};

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqa
        arm_ik_sqrt_cell u_r (.i_clk(i_clk), .i_en(en), .i_d(w_sr[k]), .o_q(w_sr[k+1]));
        arm_ik_sqrt_cell u_h (.i_clk(i_clk), .i_en(en), .i_d(w_sh[k]), .o_q(w_sh[k+1]));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_va[k+1] <= 1'b0;
            else if (en)
                r_va[k+1] <= r_va[k];
        end
        always_ff @(posedge i_clk) begin
            if (en)
                r_ca[k+1] <= r_ca[k];
        end
    end

    // stages 3..5: acos argument p/q, special cases, q*q - p*p
    logic               r_v3, r_v4;
    t_mid               r_m3, r_m4;
    logic [31:0]        r_qq;
    logic signed [35:0] r_pp;
    logic [15:0]        r_q3;
    logic signed [17:0] p3;
    logic signed [17:0] q3;
    t_mid               n_m3;

    always_comb begin
        p3 = $signed({2'b00, w_sr[SQRT_CELLS].root}) - $signed({3'b000, r_second});
        q3 = $signed({2'b00, r_first, 1'b0});
        n_m3.x  = r_ca[SQRT_CELLS].x;
        n_m3.y  = r_ca[SQRT_CELLS].y;
        n_m3.z  = r_ca[SQRT_CELLS].z;
        n_m3.sh = w_sh[SQRT_CELLS].root;
        n_m3.p  = p3;
        n_m3.spec = 1'b1;
        if (q3 == 18'sd0) begin
            if (p3 > 0)
                n_m3.spec_ang = '0;
            else if (p3 < 0)
                n_m3.spec_ang = DEG180;
            else
                n_m3.spec_ang = DEG90;
        end else if (p3 >= q3) begin
            n_m3.spec_ang = '0;
        end else if (p3 <= -q3) begin
            n_m3.spec_ang = DEG180;
        end else begin
            n_m3.spec     = 1'b0;
            n_m3.spec_ang = '0;
        end
    end

    logic        r_vb [0:SQRT_CELLS];
    t_mid        r_cb [0:SQRT_CELLS];
    logic [31:0] r_d;
    t_sqrt       w_sb [0:SQRT_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_vb[0] <= 1'b0;
        end else if (en) begin
            r_v3    <= r_va[SQRT_CELLS];
            r_v4    <= r_v3;
            r_vb[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3    <= n_m3;
            r_q3    <= {r_first, 1'b0};
            r_m4    <= r_m3;
            r_pp    <= r_m3.p * r_m3.p;
            r_qq    <= 32'(r_q3) * 32'(r_q3);
            r_cb[0] <= r_m4;
            r_d     <= r_m4.spec ? 32'd0 : (r_qq - r_pp[31:0]);
        end
    end

    assign w_sb[0] = '{rad: r_d, rem: '0, root: '0};

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqb
        arm_ik_sqrt_cell u_b (.i_clk(i_clk), .i_en(en), .i_d(w_sb[k]), .o_q(w_sb[k+1]));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_vb[k+1] <= 1'b0;
            else if (en)
                r_vb[k+1] <= r_vb[k];
        end
        always_ff @(posedge i_clk) begin
            if (en)
                r_cb[k+1] <= r_cb[k];
        end
    end

    // stage 6 prerotate, then three atan2 lanes: polar, azimuth, acos
    logic    r_vc [0:CORDIC_STEPS];
    t_spec   r_cs [0:CORDIC_STEPS];
    t_cordic r_cp, r_cz, r_cc;
    t_cordic w_cp [0:CORDIC_STEPS];
    t_cordic w_cz [0:CORDIC_STEPS];
    t_cordic w_cc [0:CORDIC_STEPS];
    t_mid    mb;

    assign mb = r_cb[SQRT_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vc[0] <= 1'b0;
        else if (en)
            r_vc[0] <= r_vb[SQRT_CELLS];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cp <= prerot({2'b00, mb.sh}, 18'(mb.y));
            r_cz <= prerot(18'(mb.x), 18'(mb.z));
            r_cc <= prerot({2'b00, w_sb[SQRT_CELLS].root}, mb.p);
            r_cs[0] <= '{spec: mb.spec, spec_ang: mb.spec_ang};
        end
    end

    assign w_cp[0] = r_cp;
    assign w_cz[0] = r_cz;
    assign w_cc[0] = r_cc;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
        arm_ik_cordic_cell u_p (.i_clk(i_clk), .i_en(en), .i_shift(5'(k)),
                                .i_d(w_cp[k]), .o_q(w_cp[k+1]));
        arm_ik_cordic_cell u_z (.i_clk(i_clk), .i_en(en), .i_shift(5'(k)),
                                .i_d(w_cz[k]), .o_q(w_cz[k+1]));
        arm_ik_cordic_cell u_c (.i_clk(i_clk), .i_en(en), .i_shift(5'(k)),
                                .i_d(w_cc[k]), .o_q(w_cc[k+1]));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_vc[k+1] <= 1'b0;
            else if (en)
                r_vc[k+1] <= r_vc[k];
        end
        always_ff @(posedge i_clk) begin
            if (en)
                r_cs[k+1] <= r_cs[k];
        end
    end

    // stage 7: joint angles; stage 8: whole degrees, offsets, clamp
    logic                    r_v7;
    logic signed [ANG_W-1:0] r_a0, r_a1, r_a2;
    logic signed [ANG_W-1:0] pol, az, ac;
    logic [3:0][7:0]         r_fin_ang;
    logic [7:0]              r_fin_rate;

    assign pol = w_cp[CORDIC_STEPS].zero ? '0 : w_cp[CORDIC_STEPS].ang;
    assign az  = w_cz[CORDIC_STEPS].zero ? '0 : w_cz[CORDIC_STEPS].ang;
    assign ac  = r_cs[CORDIC_STEPS].spec ? r_cs[CORDIC_STEPS].spec_ang :
                 (w_cc[CORDIC_STEPS].zero ? '0 : w_cc[CORDIC_STEPS].ang);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7      <= 1'b0;
            r_fin_vld <= 1'b0;
        end else if (en) begin
            r_v7      <= r_vc[CORDIC_STEPS];
            r_fin_vld <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= az;
            r_a1 <= ac + DEG90 - pol;
            r_a2 <= DEG180 - ac;
            r_fin_ang[0] <= cmd_angle(r_a0, 8'd0, r_limit);
            r_fin_ang[1] <= cmd_angle(r_a1, 8'd0, r_limit);
            r_fin_ang[2] <= cmd_angle(r_a2, r_elbow, r_limit);
            r_fin_ang[3] <= cmd_angle(r_a2, r_wrist, r_limit);
            r_fin_rate   <= r_speed;
        end
    end

    arm_ik_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_valid  (r_fin_vld),
        .i_angles      (r_fin_ang),
        .i_rate        (r_fin_rate),
        .o_take        (take),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_servo_id    (o_servo_id),
        .o_servo_angle (o_servo_angle),
        .o_servo_rate  (o_servo_rate),
        .o_last_command(o_last_command)
    );

    // a command other than the last is always followed by the rest of its item
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_command |=> o_out_valid)
        else $error("command sequence broken off");

    // input side stalls only when the last angle stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_fin_vld)
        else $error("stall without full pipeline");

    // commanded angle never above the clamp
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_servo_angle <= r_limit)
        else $error("angle above limit");

    // reset leaves nothing to deliver
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

>>> sv/arm_ik_sqrt_cell.sv
// One digit step of the integer square root chain: two radicand bits per cell.
// Depends on arm_ik_pkg.
module arm_ik_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  arm_ik_pkg::t_sqrt  i_d,
    output arm_ik_pkg::t_sqrt  o_q
);
    import arm_ik_pkg::*;

    logic [19:0] rem_s;
    logic [19:0] trial;
    t_sqrt       n_q;
    t_sqrt       r_q;

    always_comb begin
        rem_s = {i_d.rem, i_d.rad[31:30]};
        trial = {2'b00, i_d.root, 2'b01};
        n_q.rad = {i_d.rad[29:0], 2'b00};
        if (rem_s >= trial) begin
            n_q.rem  = 18'(rem_s - trial);
            n_q.root = {i_d.root[14:0], 1'b1};
        end else begin
            n_q.rem  = rem_s[17:0];
            n_q.root = {i_d.root[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

>>> sv/arm_ik_cordic_cell.sv
// One vectoring step of the atan2 chain, angle kept in degrees.
// Depends on arm_ik_pkg.
module arm_ik_cordic_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [4:0]           i_shift,
    input  arm_ik_pkg::t_cordic  i_d,
    output arm_ik_pkg::t_cordic  o_q
);
    import arm_ik_pkg::*;

    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic signed [ANG_W-1:0] step;
    t_cordic                 n_q;
    t_cordic                 r_q;

    always_comb begin
        dx = i_d.y >>> i_shift;
        dy = i_d.x >>> i_shift;
        step = step_angle(i_shift);
        n_q.zero = i_d.zero;
        if (i_d.y > 0) begin
            n_q.x   = i_d.x + dx;
            n_q.y   = i_d.y - dy;
            n_q.ang = i_d.ang + step;
        end else begin
            n_q.x   = i_d.x - dx;
            n_q.y   = i_d.y + dy;
            n_q.ang = i_d.ang - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_q <= n_q;
    end

    assign o_q = r_q;
endmodule

>>> sv/arm_ik_out.sv
// Result serializer: holds four servo angles and hands out four commands per item, one at a time.
// Depends on arm_ik_pkg.
module arm_ik_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_valid,
    input  logic [3:0][7:0] i_angles,
    input  logic [7:0]      i_rate,
    output logic            o_take,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [1:0]      o_servo_id,
    output logic [7:0]      o_servo_angle,
    output logic [7:0]      o_servo_rate,
    output logic            o_last_command
);
    import arm_ik_pkg::*;

    logic            r_busy;
    logic [1:0]      r_cnt;
    logic [3:0][7:0] r_ang;
    logic [7:0]      r_rate;
    logic            last;

    assign last   = (r_cnt == ID_WRIST);
    assign o_take = i_load_valid && (!r_busy || (last && !i_stall));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= ID_BASE;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= ID_BASE;
        end else if (r_busy && !i_stall) begin
            if (last)
                r_busy <= 1'b0;
            else
                r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ang  <= i_angles;
            r_rate <= i_rate;
        end
    end

    assign o_valid        = r_busy;
    assign o_servo_id     = r_cnt;
    assign o_servo_angle  = r_ang[r_cnt];
    assign o_servo_rate   = r_rate;
    assign o_last_command = last;
endmodule
